// File: hw/rtl/cbms_pkg.sv
// ----------------------------------------------------------------------------
// cbms_pkg
// Shared constants for the cubic Bezier midpoint subdivision block.
// ----------------------------------------------------------------------------
package cbms_pkg;

	localparam int COORD_BITS_DEFAULT = 16;
	localparam int FRAC_BITS          = 6;
	localparam int NUM_POINTS         = 13;
	localparam int IDX_BITS           = 4;
	localparam logic [IDX_BITS-1:0] LAST_INDEX = IDX_BITS'(NUM_POINTS - 1);

	// Item queue between the arithmetic pipeline and the point serializer.
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = 1;
	localparam int QUEUE_CNT_BITS = 2;

endpackage

// File: hw/rtl/cbms_front.sv
// ----------------------------------------------------------------------------
// cbms_front
// Six-stage pipeline that splits a cubic at t=1/2 twice and presents all
// thirteen control points of the four resulting segments at once.
// ----------------------------------------------------------------------------
module cbms_front #(
	parameter int COORD_BITS = cbms_pkg::COORD_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0][3:0][COORD_BITS+cbms_pkg::FRAC_BITS-1:0] in_pts,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0][cbms_pkg::NUM_POINTS-1:0][COORD_BITS+cbms_pkg::FRAC_BITS-1:0] out_pts
);

	localparam int W = COORD_BITS + cbms_pkg::FRAC_BITS;

	// Exact average: the operands always have an even sum.
	function automatic logic [W-1:0] mid(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return s[W:1];
	endfunction

	function automatic logic [4:0][W-1:0] step_a(input logic [3:0][W-1:0] c);
		logic [4:0][W-1:0] r;
		r[0] = c[0];
		r[1] = mid(c[0], c[1]);
		r[2] = mid(c[1], c[2]);
		r[3] = mid(c[2], c[3]);
		r[4] = c[3];
		return r;
	endfunction

	function automatic logic [5:0][W-1:0] step_b(input logic [4:0][W-1:0] a);
		logic [5:0][W-1:0] r;
		r[0] = a[0];
		r[1] = a[1];
		r[2] = mid(a[1], a[2]);
		r[3] = mid(a[2], a[3]);
		r[4] = a[3];
		r[5] = a[4];
		return r;
	endfunction

	function automatic logic [6:0][W-1:0] step_c(input logic [5:0][W-1:0] b);
		logic [6:0][W-1:0] r;
		r[0] = b[0];
		r[1] = b[1];
		r[2] = b[2];
		r[3] = mid(b[2], b[3]);
		r[4] = b[3];
		r[5] = b[4];
		r[6] = b[5];
		return r;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [1:0][4:0][W-1:0] a_s1;
	logic [1:0][5:0][W-1:0] b_s2;
	logic [1:0][6:0][W-1:0] h_s3;
	logic [1:0][1:0][4:0][W-1:0] a_s4;
	logic [1:0][1:0][5:0][W-1:0] b_s5;
	logic [1:0][cbms_pkg::NUM_POINTS-1:0][W-1:0] o_s6;
	logic [1:0][cbms_pkg::NUM_POINTS-1:0][W-1:0] o_d;
	logic [1:0][6:0][W-1:0] left_d;
	logic [1:0][6:0][W-1:0] right_d;

	// The whole pipeline holds only when the last stage cannot hand off.
	assign en        = !(v_s6 && !out_ready);
	assign in_ready  = en;
	assign out_valid = v_s6;
	assign out_pts   = o_s6;

	always_comb begin
		for (int d = 0; d < 2; d++) begin
			left_d[d]  = step_c(b_s5[d][0]);
			right_d[d] = step_c(b_s5[d][1]);
			o_d[d][6:0]  = left_d[d];
			o_d[d][12:7] = right_d[d][6:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < 2; d++) begin
				a_s1[d]    <= step_a(in_pts[d]);
				b_s2[d]    <= step_b(a_s1[d]);
				h_s3[d]    <= step_c(b_s2[d]);
				a_s4[d][0] <= step_a(h_s3[d][3:0]);
				a_s4[d][1] <= step_a(h_s3[d][6:3]);
				b_s5[d][0] <= step_b(a_s4[d][0]);
				b_s5[d][1] <= step_b(a_s4[d][1]);
			end
			o_s6 <= o_d;
		end
	end

endmodule

// File: hw/rtl/cbms_queue.sv
// ----------------------------------------------------------------------------
// cbms_queue
// Short first-in first-out queue of fully computed items.
// ----------------------------------------------------------------------------
module cbms_queue #(
	parameter int DATA_W = 2 * cbms_pkg::NUM_POINTS
		* (cbms_pkg::COORD_BITS_DEFAULT + cbms_pkg::FRAC_BITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic [DATA_W-1:0] rd_data,
	output logic              empty
);

	logic [DATA_W-1:0] mem_q [cbms_pkg::QUEUE_DEPTH];
	logic [cbms_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [cbms_pkg::QUEUE_CNT_BITS-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full    = cnt_q == cbms_pkg::QUEUE_CNT_BITS'(cbms_pkg::QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hw/rtl/cbms_back.sv
// ----------------------------------------------------------------------------
// cbms_back
// Walks the thirteen points of the item at the queue head into an output
// register, one point per beat while pop keeps draining that register.
// ----------------------------------------------------------------------------
module cbms_back #(
	parameter int COORD_BITS = cbms_pkg::COORD_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  logic [1:0][cbms_pkg::NUM_POINTS-1:0][COORD_BITS+cbms_pkg::FRAC_BITS-1:0] q_pts,
	output logic q_pop,
	output logic empty,
	input  logic pop,
	output logic [COORD_BITS+cbms_pkg::FRAC_BITS-1:0] pt_x,
	output logic [COORD_BITS+cbms_pkg::FRAC_BITS-1:0] pt_y,
	output logic [cbms_pkg::IDX_BITS-1:0] pt_index,
	output logic pt_last
);

	localparam int W = COORD_BITS + cbms_pkg::FRAC_BITS;

	logic [cbms_pkg::IDX_BITS-1:0] cnt_q;
	logic                          ovalid_q;
	logic [W-1:0]                  x_q, y_q;
	logic [cbms_pkg::IDX_BITS-1:0] idx_q;
	logic                          last_q;
	logic                          load;
	logic                          at_last;

	assign at_last  = cnt_q == cbms_pkg::LAST_INDEX;
	// The output register refills in the same cycle it is drained, when the queue holds an item.
	assign load     = !q_empty && (!ovalid_q || pop);
	assign q_pop    = load && at_last;
	assign empty    = !ovalid_q;
	assign pt_x     = x_q;
	assign pt_y     = y_q;
	assign pt_index = idx_q;
	assign pt_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				ovalid_q <= 1'b1;
				cnt_q    <= at_last ? '0 : cnt_q + 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= q_pts[0][cnt_q];
			y_q    <= q_pts[1][cnt_q];
			idx_q  <= cnt_q;
			last_q <= at_last;
		end
	end

endmodule

// File: hw/rtl/cubic_bezier_midpoint_subdivide.sv
// The first point of an item reaches the result ports through the front pipeline, the queue and
// the output register. Throughput: one point per cycle while pop keeps draining the output
// register, the single register that serializes the thirteen points.
// Up to eight items are taken back to back before full rises: six pipeline stages and two queue
// slots, one of which still holds the item being serialized. Reset clears all valid bits,
// pointers and the point counter.
// ----------------------------------------------------------------------------
// cubic_bezier_midpoint_subdivide
// Two-level de Casteljau midpoint subdivision of a cubic Bezier, emitting the
// thirteen control points of the four resulting segments in curve order.
// ----------------------------------------------------------------------------
module cubic_bezier_midpoint_subdivide #(
	parameter int COORD_BITS = cbms_pkg::COORD_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [COORD_BITS-1:0] p0_x,
	input  logic signed [COORD_BITS-1:0] p0_y,
	input  logic signed [COORD_BITS-1:0] p1_x,
	input  logic signed [COORD_BITS-1:0] p1_y,
	input  logic signed [COORD_BITS-1:0] p2_x,
	input  logic signed [COORD_BITS-1:0] p2_y,
	input  logic signed [COORD_BITS-1:0] p3_x,
	input  logic signed [COORD_BITS-1:0] p3_y,
	output logic empty,
	input  logic pop,
	output logic signed [COORD_BITS+cbms_pkg::FRAC_BITS-1:0] out_x,
	output logic signed [COORD_BITS+cbms_pkg::FRAC_BITS-1:0] out_y,
	output logic [cbms_pkg::IDX_BITS-1:0] point_index,
	output logic last_point
);

	localparam int W      = COORD_BITS + cbms_pkg::FRAC_BITS;
	localparam int DATA_W = 2 * cbms_pkg::NUM_POINTS * W;

	logic [1:0][3:0][W-1:0] in_pts;
	logic in_ready;
	logic f_valid, f_ready;
	logic [1:0][cbms_pkg::NUM_POINTS-1:0][W-1:0] f_pts;
	logic [1:0][cbms_pkg::NUM_POINTS-1:0][W-1:0] q_pts;
	logic [DATA_W-1:0] q_rd_data;
	logic q_full, q_empty, q_pop;
	logic [W-1:0] pt_x, pt_y;

	// Scale to six fractional bits so every average below is exact.
	assign in_pts[0][0] = {p0_x, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[0][1] = {p1_x, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[0][2] = {p2_x, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[0][3] = {p3_x, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[1][0] = {p0_y, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[1][1] = {p1_y, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[1][2] = {p2_y, {cbms_pkg::FRAC_BITS{1'b0}}};
	assign in_pts[1][3] = {p3_y, {cbms_pkg::FRAC_BITS{1'b0}}};

	assign full    = !in_ready;
	assign f_ready = !q_full;
	assign q_pts   = q_rd_data;
	assign out_x   = $signed(pt_x);
	assign out_y   = $signed(pt_y);

	cbms_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push),
		.in_ready (in_ready),
		.in_pts   (in_pts),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_pts  (f_pts)
	);

	cbms_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_valid),
		.wr_data(f_pts),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	cbms_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pts   (q_pts),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.pt_x    (pt_x),
		.pt_y    (pt_y),
		.pt_index(point_index),
		.pt_last (last_point)
	);

endmodule
